// File: hw/rtl/rgag_pkg.sv
// Shared constants, register indexes and helper functions of the radial glow alpha generator.
package rgag_pkg;

  localparam int unsigned SIZE_W   = 9;
  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned CH_W     = 8;
  localparam int unsigned ALPHA_W  = 8;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GLOW_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLOW_COLOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALLOFF_GAIN = 2'd2;

  localparam logic [SIZE_W-1:0]  GLOW_SIZE_RST    = 9'd64;
  localparam logic [COLOR_W-1:0] GLOW_COLOR_RST   = 24'hFFFFFF;
  localparam logic [GAIN_W-1:0]  FALLOFF_GAIN_RST = 16'd1280;

  // Exact floor(p / 255) for any product of two 8-bit values.
  function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] p);
    logic [2*CH_W:0] t;
    t = (2*CH_W+1)'(p) + (2*CH_W+1)'(1) + (2*CH_W+1)'(p[2*CH_W-1:CH_W]);
    return t[2*CH_W-1:CH_W];
  endfunction

  function automatic logic [CH_W-1:0] premul(input logic [CH_W-1:0] c,
                                             input logic [ALPHA_W-1:0] a);
    logic [2*CH_W-1:0] p;
    p = (2*CH_W)'(c) * (2*CH_W)'(a);
    return div255(p);
  endfunction

endpackage

// File: hw/rtl/rgag_prep.sv
// Front pipeline: distance, squared radius, gain product and the dividend and divisor.
module rgag_prep import rgag_pkg::*; #(
  parameter int unsigned MAX_SIZE = 256,
  parameter int unsigned SW       = $clog2(MAX_SIZE + 1),
  parameter int unsigned NUMW     = 2 * SW + 10,
  parameter int unsigned RW       = NUMW + 8,
  parameter int unsigned DW       = NUMW + 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [PIX_W-1:0]  pixel_x_i,
  input  logic [PIX_W-1:0]  pixel_y_i,
  input  logic [SIZE_W-1:0] glow_size_i,
  input  logic [GAIN_W-1:0] falloff_gain_i,
  output logic              valid_o,
  output logic [RW-1:0]     num_o,
  output logic [DW-1:0]     den_o
);

  localparam int unsigned XW = ((SW > PIX_W + 1) ? SW : PIX_W + 1) + 1;
  localparam int unsigned QW = 2 * SW + 1;
  localparam int unsigned KW = GAIN_W + QW;

  logic [SW-1:0]        s_sat;
  logic                 in_sprite;
  logic signed [XW-1:0] dx, dy, adx_full, ady_full;

  logic                 v0_q, v1_q, v2_q, v3_q;
  logic                 in0_q, in1_q, in2_q;
  logic [SW-1:0]        adx_q, ady_q, s0_q;
  logic [QW-1:0]        q_d, q_q;
  logic [2*SW-1:0]      s2_d, s2_q;
  logic [KW-1:0]        kq_d, kq_q;
  logic [NUMW-1:0]      numf_q;
  logic [NUMW-1:0]      diff;
  logic [RW-1:0]        num_d, num_q;
  logic [DW-1:0]        den_d, den_q;

  always_comb begin
    s_sat  = (32'(glow_size_i) > MAX_SIZE) ? SW'(MAX_SIZE) : SW'(glow_size_i);
    in_sprite = (32'(pixel_x_i) < 32'(s_sat)) && (32'(pixel_y_i) < 32'(s_sat));
    dx = $signed(XW'({pixel_x_i, 1'b0})) - $signed(XW'(s_sat));
    dy = $signed(XW'({pixel_y_i, 1'b0})) - $signed(XW'(s_sat));
    adx_full = dx[XW-1] ? -dx : dx;
    ady_full = dy[XW-1] ? -dy : dy;
  end

  always_comb begin
    q_d  = QW'((2*SW)'(adx_q) * (2*SW)'(adx_q)) + QW'((2*SW)'(ady_q) * (2*SW)'(ady_q));
    s2_d = (2*SW)'(s0_q) * (2*SW)'(s0_q);
    kq_d = KW'(falloff_gain_i) * KW'(q_q);
  end

  always_comb begin
    diff  = numf_q - kq_q[NUMW-1:0];
    num_d = '0;
    den_d = DW'(1);
    if (in2_q && (KW'(numf_q) > kq_q)) begin
      num_d = (RW'(diff) << 8) - RW'(diff);
      den_d = DW'(numf_q) + (DW'(kq_q[NUMW-1:0]) << 2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adx_q  <= adx_full[SW-1:0];
      ady_q  <= ady_full[SW-1:0];
      s0_q   <= s_sat;
      in0_q  <= in_sprite;
      q_q    <= q_d;
      s2_q   <= s2_d;
      in1_q  <= in0_q;
      kq_q   <= kq_d;
      numf_q <= NUMW'(s2_q) << 10;
      in2_q  <= in1_q;
      num_q  <= num_d;
      den_q  <= den_d;
    end
  end

  assign valid_o = v3_q;
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule

// File: hw/rtl/rgag_div_cell.sv
// One restoring division cell that settles one alpha bit and passes the remainder on.
module rgag_div_cell import rgag_pkg::*; #(
  parameter int unsigned RW = 36,
  parameter int unsigned DW = 31,
  parameter int unsigned SH = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [RW-1:0]      rem_i,
  input  logic [DW-1:0]      den_i,
  input  logic [ALPHA_W-1:0] quo_i,
  output logic               valid_o,
  output logic [RW-1:0]      rem_o,
  output logic [DW-1:0]      den_o,
  output logic [ALPHA_W-1:0] quo_o
);

  localparam int unsigned CW = (RW > DW + SH) ? RW : DW + SH;

  logic [CW-1:0]      rem_x, sub_x, diff;
  logic               fit;
  logic               valid_q;
  logic [RW-1:0]      rem_d, rem_q;
  logic [DW-1:0]      den_q;
  logic [ALPHA_W-1:0] quo_d, quo_q;

  always_comb begin
    rem_x = CW'(rem_i);
    sub_x = CW'(den_i) << SH;
    fit   = rem_x >= sub_x;
    diff  = rem_x - sub_x;
    rem_d = fit ? diff[RW-1:0] : rem_i;
    quo_d = {quo_i[ALPHA_W-2:0], fit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_i;
      quo_q <= quo_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;

endmodule

// File: hw/rtl/radial_glow_alpha_generator.sv
// Top level of the radial glow alpha generator: config registers, divider chain, output stage.
//
//   Channel  Direction  Handshake                      Payload
//   s_axis   in         s_axis_tvalid/s_axis_tready    pixel_x, pixel_y
//   m_axis   out        m_axis_tvalid/m_axis_tready    out_blue, out_green, out_red, out_alpha
//   cfg      in         cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// One word is accepted per cycle while s_axis_tready is high.
// Four front stages form the divisor and dividend, eight division cells settle one alpha bit
// each, and one output register applies the premultiply.
// A held output word freezes the whole pipeline; s_axis_tready is high whenever the output
// register is empty or is being taken. Reset clears all valid flags and loads the register
// defaults; the config port is always ready.
module radial_glow_alpha_generator import rgag_pkg::*; #(
  parameter int unsigned MAX_SIZE = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,   // pixel_x, pixel_y
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,   // out_blue, out_green, out_red, out_alpha
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COLOR_W-1:0]   cfg_data_i
);

  localparam int unsigned SW   = $clog2(MAX_SIZE + 1);
  localparam int unsigned NUMW = 2 * SW + 10;
  localparam int unsigned RW   = NUMW + 8;
  localparam int unsigned DW   = NUMW + 3;

  logic [SIZE_W-1:0]  glow_size_q;
  logic [COLOR_W-1:0] glow_color_q;
  logic [GAIN_W-1:0]  falloff_gain_q;

  logic               en;
  logic               valid_c [ALPHA_W+1];
  logic [RW-1:0]      rem_c   [ALPHA_W+1];
  logic [DW-1:0]      den_c   [ALPHA_W+1];
  logic [ALPHA_W-1:0] quo_c   [ALPHA_W+1];

  logic               out_valid_q;
  logic [31:0]        out_data_d, out_data_q;
  logic [ALPHA_W-1:0] alpha;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glow_size_q    <= GLOW_SIZE_RST;
      glow_color_q   <= GLOW_COLOR_RST;
      falloff_gain_q <= FALLOFF_GAIN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GLOW_SIZE:    glow_size_q    <= cfg_data_i[SIZE_W-1:0];
        REG_GLOW_COLOR:   glow_color_q   <= cfg_data_i;
        REG_FALLOFF_GAIN: falloff_gain_q <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  rgag_prep #(
    .MAX_SIZE (MAX_SIZE),
    .SW       (SW),
    .NUMW     (NUMW),
    .RW       (RW),
    .DW       (DW)
  ) u_prep (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (s_axis_tvalid),
    .pixel_x_i      (s_axis_tdata[7:0]),
    .pixel_y_i      (s_axis_tdata[15:8]),
    .glow_size_i    (glow_size_q),
    .falloff_gain_i (falloff_gain_q),
    .valid_o        (valid_c[0]),
    .num_o          (rem_c[0]),
    .den_o          (den_c[0])
  );

  assign quo_c[0] = '0;

  for (genvar i = 0; i < ALPHA_W; i++) begin : g_cell
    rgag_div_cell #(
      .RW (RW),
      .DW (DW),
      .SH (ALPHA_W - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_c[i]),
      .rem_i   (rem_c[i]),
      .den_i   (den_c[i]),
      .quo_i   (quo_c[i]),
      .valid_o (valid_c[i+1]),
      .rem_o   (rem_c[i+1]),
      .den_o   (den_c[i+1]),
      .quo_o   (quo_c[i+1])
    );
  end

  assign alpha = quo_c[ALPHA_W];

  always_comb begin
    out_data_d = {alpha,
                  premul(glow_color_q[7:0], alpha),
                  premul(glow_color_q[15:8], alpha),
                  premul(glow_color_q[23:16], alpha)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_c[ALPHA_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: hw/rtl/rgag_checker.sv
// Port-level checker for the radial glow alpha generator and its bind statement.
module rgag_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input not ready while output register is empty");

  a_zero_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[31:24] == '0) |-> (m_axis_tdata[23:0] == '0))
    else $error("color nonzero with zero alpha");

  a_channel_le_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] <= m_axis_tdata[31:24]) &&
                      (m_axis_tdata[15:8] <= m_axis_tdata[31:24]) &&
                      (m_axis_tdata[23:16] <= m_axis_tdata[31:24]))
    else $error("premultiplied channel exceeds alpha");

endmodule

bind radial_glow_alpha_generator rgag_checker u_rgag_checker (.*);
